/* sv/gamepad_input_conditioner_core_assert.svh */
// Assertion macros for the gamepad input conditioner.
// Each macro expects signals named clk and rst in the including module.
`ifndef GAMEPAD_INPUT_CONDITIONER_CORE_ASSERT_SVH
`define GAMEPAD_INPUT_CONDITIONER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GIC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gamepad input conditioner: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define GIC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gamepad input conditioner: next-cycle check failed");

`endif

/* sv/gic_pkg.sv */
// Package for the gamepad input conditioner: constants, register codes,
// sequencer states and the divider request and response types. No dependencies.
`timescale 1ns / 1ps

package gic_pkg;

  localparam int PORT_COUNT = 4;
  localparam int PORT_W     = 2;
  localparam int PORT_SLOTS = 2 ** PORT_W;
  localparam int SUM_CAP    = 4;
  localparam int COUNT_W    = 3;
  localparam int SUM_W      = 10;
  localparam int DIV_W      = 16;
  localparam int DIV_STEP_W = 5;
  localparam int MOD_STEPS  = DIV_W;
  localparam int AVG_STEPS  = SUM_W;
  localparam int AVG_SHIFT  = DIV_W - SUM_W;
  localparam int PADDR_W    = 4;

  localparam logic [1:0] REG_REPEAT_DELAY    = 2'd0;
  localparam logic [1:0] REG_REPEAT_PERIOD   = 2'd1;
  localparam logic [1:0] REG_STICK_THRESHOLD = 2'd2;
  localparam logic [1:0] REG_BUTTON_MASK     = 2'd3;

  localparam logic [15:0] RESET_REPEAT_DELAY    = 16'd15;
  localparam logic [15:0] RESET_REPEAT_PERIOD   = 16'd5;
  localparam logic [6:0]  RESET_STICK_THRESHOLD = 7'd50;
  localparam logic [15:0] RESET_BUTTON_MASK     = 16'hFFFF;

  localparam logic [3:0] DIR_LEFT  = 4'b0001;
  localparam logic [3:0] DIR_RIGHT = 4'b0010;
  localparam logic [3:0] DIR_DOWN  = 4'b0100;
  localparam logic [3:0] DIR_UP    = 4'b1000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MOD,
    ST_AVG_START,
    ST_AVGX,
    ST_AVGY,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_W-1:0]      dividend;
    logic [DIV_W-1:0]      divisor;
    logic [DIV_STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage

/* sv/gic_div.sv */
// Shared restoring divider for the gamepad input conditioner, one quotient
// bit per cycle over a requested number of steps. Depends on gic_pkg.
`timescale 1ns / 1ps

module gic_div (
  input  logic             clk,
  input  logic             rst,
  input  gic_pkg::div_req_t req,
  output gic_pkg::div_rsp_t rsp
);

  logic                           busy;
  logic                           done;
  logic [gic_pkg::DIV_STEP_W-1:0] cnt;
  logic [gic_pkg::DIV_W-1:0]      rem;
  logic [gic_pkg::DIV_W-1:0]      quo;
  logic [gic_pkg::DIV_W-1:0]      dsr;
  logic [gic_pkg::DIV_W:0]        trial;
  logic [gic_pkg::DIV_W:0]        trial_sub;
  logic                           fits;

  assign trial     = {rem, quo[gic_pkg::DIV_W-1]};
  assign fits      = trial >= {1'b0, dsr};
  assign trial_sub = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == gic_pkg::DIV_STEP_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - gic_pkg::DIV_STEP_W'(1);
        if (cnt == gic_pkg::DIV_STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      rem <= fits ? trial_sub[gic_pkg::DIV_W-1:0] : trial[gic_pkg::DIV_W-1:0];
      quo <= {quo[gic_pkg::DIV_W-2:0], fits};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quo;
  assign rsp.rem  = rem;

endmodule

/* sv/gamepad_input_conditioner_core.sv */
// Gamepad input conditioner top level: per-port edge detection, autorepeat and
// frame averaging. Depends on gic_pkg, gic_div and the assertion header.
// The latched word is evaluated, then the shared divider forms a remainder when the repeat
// phase needs one, and the x and y means at a frame end that forms a mean.
// A new word is accepted only after the result is loaded into the output register; the shared divider is used in turn.
// Synchronous reset restores register defaults and clears all per-port and frame state.
`timescale 1ns / 1ps
`include "gamepad_input_conditioner_core_assert.svh"

module gamepad_input_conditioner_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   port,
  input  logic                         port_error,
  input  logic [15:0]                  raw_buttons,
  input  logic signed [7:0]            stick_x,
  input  logic signed [7:0]            stick_y,
  input  logic                         frame_last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [15:0]                  buttons_held,
  output logic [15:0]                  buttons_pressed,
  output logic [15:0]                  buttons_released,
  output logic [3:0]                   stick_dir,
  output logic [3:0]                   stick_dir_pressed,
  output logic [3:0]                   stick_dir_released,
  output logic                         repeat_pulse,
  output logic                         port_lost,
  output logic                         port_live,
  output logic                         frame_done,
  output logic signed [7:0]            avg_stick_x,
  output logic signed [7:0]            avg_stick_y,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gic_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int SW = gic_pkg::SUM_W;
  localparam int CW = gic_pkg::COUNT_W;

  gic_pkg::state_t   state;
  gic_pkg::state_t   state_next;
  gic_pkg::div_req_t div_req;
  gic_pkg::div_rsp_t div_rsp;

  logic [15:0] repeat_delay;
  logic [15:0] repeat_period;
  logic [6:0]  stick_threshold;
  logic [15:0] button_mask;
  logic [1:0]  cfg_index;
  logic        cfg_write;

  logic [gic_pkg::PORT_W-1:0] port_r;
  logic                       err_r;
  logic [15:0]                raw_r;
  logic [7:0]                 sx_r;
  logic [7:0]                 sy_r;
  logic                       last_r;

  logic [15:0] prev_buttons   [gic_pkg::PORT_SLOTS];
  logic [3:0]  prev_direction [gic_pkg::PORT_SLOTS];
  logic [15:0] hold_count     [gic_pkg::PORT_SLOTS];
  logic        port_dead      [gic_pkg::PORT_SLOTS];
  logic [SW-1:0] frame_sum_x;
  logic [SW-1:0] frame_sum_y;
  logic [CW-1:0] frame_live_count;
  logic [7:0]    last_avg_x;
  logic [7:0]    last_avg_y;

  logic [15:0] res_held;
  logic [15:0] res_pressed;
  logic [15:0] res_released;
  logic [3:0]  res_dir;
  logic [3:0]  res_dpressed;
  logic [3:0]  res_dreleased;
  logic        res_pulse;
  logic        res_lost;
  logic        res_live;
  logic        res_done;
  logic        avg_pending;
  logic [SW-1:0] avg_num_x;
  logic [SW-1:0] avg_num_y;
  logic [CW-1:0] avg_den;

  logic               present;
  logic               alive;
  logic               go_dead;
  logic               is_live;
  logic [15:0]        held_c;
  logic [15:0]        pb;
  logic [3:0]         pd;
  logic [3:0]         dir_c;
  logic signed [8:0]  sx9;
  logic signed [8:0]  sy9;
  logic signed [8:0]  thr9;
  logic signed [8:0]  neg_thr9;
  logic               holding;
  logic [15:0]        hc;
  logic [15:0]        hc_inc;
  logic               not_sat;
  logic [15:0]        per_c;
  logic               reach;
  logic [15:0]        phase;
  logic               repeat_hit;
  logic               need_mod;
  logic               pulse_now;
  logic               add_frame;
  logic [SW-1:0]      sum_x_new;
  logic [SW-1:0]      sum_y_new;
  logic [CW-1:0]      count_new;
  logic               avg_needed;
  logic               out_load;
  logic [SW-1:0]      mag_x;
  logic [SW-1:0]      mag_y;
  logic [SW-1:0]      quot_s;
  logic [SW-1:0]      quot_neg;

  gic_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    unique case (cfg_index)
      gic_pkg::REG_REPEAT_DELAY:    prdata = {16'd0, repeat_delay};
      gic_pkg::REG_REPEAT_PERIOD:   prdata = {16'd0, repeat_period};
      gic_pkg::REG_STICK_THRESHOLD: prdata = {25'd0, stick_threshold};
      gic_pkg::REG_BUTTON_MASK:     prdata = {16'd0, button_mask};
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_delay    <= gic_pkg::RESET_REPEAT_DELAY;
      repeat_period   <= gic_pkg::RESET_REPEAT_PERIOD;
      stick_threshold <= gic_pkg::RESET_STICK_THRESHOLD;
      button_mask     <= gic_pkg::RESET_BUTTON_MASK;
    end else if (cfg_write) begin
      unique case (cfg_index)
        gic_pkg::REG_REPEAT_DELAY:    repeat_delay    <= pwdata[15:0];
        gic_pkg::REG_REPEAT_PERIOD:   repeat_period   <= pwdata[15:0];
        gic_pkg::REG_STICK_THRESHOLD: stick_threshold <= pwdata[6:0];
        gic_pkg::REG_BUTTON_MASK:     button_mask     <= pwdata[15:0];
        default:                      ;
      endcase
    end
  end

  // Per-port evaluation of the latched word.
  assign present  = {2'b00, port_r} < 4'(gic_pkg::PORT_COUNT);
  assign alive    = present && !port_dead[port_r];
  assign go_dead  = alive && err_r;
  assign is_live  = alive && !err_r;
  assign held_c   = raw_r & button_mask;
  assign pb       = prev_buttons[port_r];
  assign pd       = prev_direction[port_r];
  assign sx9      = signed'({sx_r[7], sx_r});
  assign sy9      = signed'({sy_r[7], sy_r});
  assign thr9     = signed'({2'b00, stick_threshold});
  assign neg_thr9 = -thr9;

  always_comb begin
    dir_c = '0;
    if (sx9 < neg_thr9) begin
      dir_c = dir_c | gic_pkg::DIR_LEFT;
    end else if (sx9 > thr9) begin
      dir_c = dir_c | gic_pkg::DIR_RIGHT;
    end
    if (sy9 < neg_thr9) begin
      dir_c = dir_c | gic_pkg::DIR_DOWN;
    end else if (sy9 > thr9) begin
      dir_c = dir_c | gic_pkg::DIR_UP;
    end
  end

  assign holding    = ((held_c != '0) || (dir_c != '0)) && (held_c == pb) && (dir_c == pd);
  assign hc         = hold_count[port_r];
  assign hc_inc     = hc + 16'd1;
  assign not_sat    = hc != 16'hFFFF;
  assign per_c      = (repeat_period == '0) ? 16'd1 : repeat_period;
  assign reach      = hc_inc >= repeat_delay;
  assign phase      = hc_inc - repeat_delay;
  assign repeat_hit = is_live && holding && not_sat && reach;
  assign need_mod   = repeat_hit && (per_c != 16'd1);
  assign pulse_now  = repeat_hit && (per_c == 16'd1);

  assign add_frame  = is_live && (frame_live_count < CW'(gic_pkg::SUM_CAP));
  assign sum_x_new  = add_frame ? frame_sum_x + {{(SW-8){sx_r[7]}}, sx_r} : frame_sum_x;
  assign sum_y_new  = add_frame ? frame_sum_y + {{(SW-8){sy_r[7]}}, sy_r} : frame_sum_y;
  assign count_new  = add_frame ? frame_live_count + CW'(1) : frame_live_count;
  assign avg_needed = last_r && (count_new != '0);

  assign mag_x    = avg_num_x[SW-1] ? (~avg_num_x + SW'(1)) : avg_num_x;
  assign mag_y    = avg_num_y[SW-1] ? (~avg_num_y + SW'(1)) : avg_num_y;
  assign quot_s   = div_rsp.quot[SW-1:0];
  assign quot_neg = ~quot_s + SW'(1);

  assign in_stall = (state != gic_pkg::ST_IDLE);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gic_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_req    = '0;
    out_load   = 1'b0;
    unique case (state)
      gic_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = gic_pkg::ST_EVAL;
        end
      end
      gic_pkg::ST_EVAL: begin
        priority if (need_mod) begin
          div_req.start    = 1'b1;
          div_req.dividend = phase;
          div_req.divisor  = per_c;
          div_req.steps    = gic_pkg::DIV_STEP_W'(gic_pkg::MOD_STEPS);
          state_next       = gic_pkg::ST_MOD;
        end else if (avg_needed) begin
          state_next = gic_pkg::ST_AVG_START;
        end else begin
          state_next = gic_pkg::ST_DONE;
        end
      end
      gic_pkg::ST_MOD: begin
        if (div_rsp.done) begin
          state_next = avg_pending ? gic_pkg::ST_AVG_START : gic_pkg::ST_DONE;
        end
      end
      gic_pkg::ST_AVG_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = {mag_x, {gic_pkg::AVG_SHIFT{1'b0}}};
        div_req.divisor  = gic_pkg::DIV_W'(avg_den);
        div_req.steps    = gic_pkg::DIV_STEP_W'(gic_pkg::AVG_STEPS);
        state_next       = gic_pkg::ST_AVGX;
      end
      gic_pkg::ST_AVGX: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = {mag_y, {gic_pkg::AVG_SHIFT{1'b0}}};
          div_req.divisor  = gic_pkg::DIV_W'(avg_den);
          div_req.steps    = gic_pkg::DIV_STEP_W'(gic_pkg::AVG_STEPS);
          state_next       = gic_pkg::ST_AVGY;
        end
      end
      gic_pkg::ST_AVGY: begin
        if (div_rsp.done) begin
          state_next = gic_pkg::ST_DONE;
        end
      end
      gic_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = gic_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gic_pkg::ST_IDLE;
      end
    endcase
  end

  // Input capture and per-word results.
  always_ff @(posedge clk) begin
    if ((state == gic_pkg::ST_IDLE) && in_valid) begin
      port_r <= port;
      err_r  <= port_error;
      raw_r  <= raw_buttons;
      sx_r   <= stick_x;
      sy_r   <= stick_y;
      last_r <= frame_last;
    end
    if (state == gic_pkg::ST_EVAL) begin
      res_held      <= is_live ? held_c : '0;
      res_pressed   <= is_live ? ((pb ^ held_c) & held_c) : '0;
      res_released  <= is_live ? ((pb ^ held_c) & pb) : '0;
      res_dir       <= is_live ? dir_c : '0;
      res_dpressed  <= is_live ? ((pd ^ dir_c) & dir_c) : '0;
      res_dreleased <= is_live ? ((pd ^ dir_c) & pd) : '0;
      res_pulse     <= pulse_now;
      res_lost      <= go_dead;
      res_live      <= is_live;
      res_done      <= avg_needed;
      avg_num_x     <= sum_x_new;
      avg_num_y     <= sum_y_new;
      avg_den       <= count_new;
    end
    if ((state == gic_pkg::ST_MOD) && div_rsp.done) begin
      res_pulse <= (div_rsp.rem == '0);
    end
  end

  // Per-port and frame state.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < gic_pkg::PORT_SLOTS; i++) begin
        prev_buttons[i]   <= '0;
        prev_direction[i] <= '0;
        hold_count[i]     <= '0;
        port_dead[i]      <= 1'b0;
      end
      frame_sum_x      <= '0;
      frame_sum_y      <= '0;
      frame_live_count <= '0;
      last_avg_x       <= '0;
      last_avg_y       <= '0;
      avg_pending      <= 1'b0;
    end else begin
      if (state == gic_pkg::ST_EVAL) begin
        avg_pending <= avg_needed;
        if (go_dead) begin
          port_dead[port_r] <= 1'b1;
        end
        if (is_live) begin
          prev_buttons[port_r]   <= held_c;
          prev_direction[port_r] <= dir_c;
          if (!holding) begin
            hold_count[port_r] <= '0;
          end else if (not_sat) begin
            hold_count[port_r] <= hc_inc;
          end
        end
        if (last_r) begin
          frame_sum_x      <= '0;
          frame_sum_y      <= '0;
          frame_live_count <= '0;
        end else begin
          frame_sum_x      <= sum_x_new;
          frame_sum_y      <= sum_y_new;
          frame_live_count <= count_new;
        end
      end
      if ((state == gic_pkg::ST_AVGX) && div_rsp.done) begin
        last_avg_x <= avg_num_x[SW-1] ? quot_neg[7:0] : quot_s[7:0];
      end
      if ((state == gic_pkg::ST_AVGY) && div_rsp.done) begin
        last_avg_y <= avg_num_y[SW-1] ? quot_neg[7:0] : quot_s[7:0];
      end
    end
  end

  // Output register for the result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      buttons_held       <= res_held;
      buttons_pressed    <= res_pressed;
      buttons_released   <= res_released;
      stick_dir          <= res_dir;
      stick_dir_pressed  <= res_dpressed;
      stick_dir_released <= res_dreleased;
      repeat_pulse       <= res_pulse;
      port_lost          <= res_lost;
      port_live          <= res_live;
      frame_done         <= res_done;
      avg_stick_x        <= signed'(last_avg_x);
      avg_stick_y        <= signed'(last_avg_y);
    end
  end

  `GIC_ASSERT_NXT(a_accept_to_eval, in_valid && !in_stall, state == gic_pkg::ST_EVAL)
  `GIC_ASSERT_IMP(a_div_start_free, div_req.start, !div_rsp.busy)
  `GIC_ASSERT_IMP(a_div_done_owner, div_rsp.done,
                  state == gic_pkg::ST_MOD || state == gic_pkg::ST_AVGX ||
                  state == gic_pkg::ST_AVGY)
  `GIC_ASSERT_IMP(a_count_cap, 1'b1, frame_live_count <= CW'(gic_pkg::SUM_CAP))
  `GIC_ASSERT_IMP(a_load_free, out_load, !out_valid || !out_stall)

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for gamepad_input_conditioner_core: a scoreboard class predicts
// each result word from the accepted poll words. Directed and random traffic is used.
// Depends on gic_pkg and the conditioner RTL only.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT     = 6000000;
  localparam int SETTLE_CYCLES   = 60;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int ITEMS_PER_PHASE = 325;
  localparam int MAX_REPORTS     = 10;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [1:0]  port;
    logic        port_error;
    logic [15:0] raw_buttons;
    logic [7:0]  stick_x;
    logic [7:0]  stick_y;
    logic        frame_last;
  } poll_t;

  typedef struct packed {
    logic [15:0] held;
    logic [15:0] pressed;
    logic [15:0] released;
    logic [3:0]  dir;
    logic [3:0]  dir_pressed;
    logic [3:0]  dir_released;
    logic        pulse;
    logic        lost;
    logic        live;
    logic        done;
    logic [7:0]  avg_x;
    logic [7:0]  avg_y;
  } pad_word_t;

  class pad_tracker;
    logic [15:0] rep_delay;
    logic [15:0] rep_period;
    logic [6:0]  threshold;
    logic [15:0] btn_mask;
    logic [15:0] prev_btn [gic_pkg::PORT_SLOTS];
    logic [3:0]  prev_dir [gic_pkg::PORT_SLOTS];
    logic [15:0] hold_cnt [gic_pkg::PORT_SLOTS];
    bit          dead [gic_pkg::PORT_SLOTS];
    int          sum_x;
    int          sum_y;
    int          live_cnt;
    logic [7:0]  mean_x;
    logic [7:0]  mean_y;
    pad_word_t   due_words [$];
    int          bad_words;

    function new();
      rep_delay  = gic_pkg::RESET_REPEAT_DELAY;
      rep_period = gic_pkg::RESET_REPEAT_PERIOD;
      threshold  = gic_pkg::RESET_STICK_THRESHOLD;
      btn_mask   = gic_pkg::RESET_BUTTON_MASK;
      for (int i = 0; i < gic_pkg::PORT_SLOTS; i++) begin
        prev_btn[i] = '0;
        prev_dir[i] = '0;
        hold_cnt[i] = '0;
        dead[i]     = 1'b0;
      end
      sum_x     = 0;
      sum_y     = 0;
      live_cnt  = 0;
      mean_x    = '0;
      mean_y    = '0;
      bad_words = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        gic_pkg::REG_REPEAT_DELAY:    rep_delay  = value[15:0];
        gic_pkg::REG_REPEAT_PERIOD:   rep_period = value[15:0];
        gic_pkg::REG_STICK_THRESHOLD: threshold  = value[6:0];
        gic_pkg::REG_BUTTON_MASK:     btn_mask   = value[15:0];
        default: ;
      endcase
    endfunction

    function void note_poll(poll_t p);
      pad_word_t   w;
      int          sx;
      int          sy;
      int          thr;
      int          c;
      int          per;
      int          i;
      int          q;
      logic [15:0] diff;
      logic [3:0]  ddiff;
      w   = '0;
      sx  = int'($signed(p.stick_x));
      sy  = int'($signed(p.stick_y));
      thr = int'(threshold);
      i   = int'(p.port);
      if (i < gic_pkg::PORT_COUNT && !dead[i]) begin
        if (p.port_error) begin
          dead[i] = 1'b1;
          w.lost  = 1'b1;
        end else begin
          w.live      = 1'b1;
          w.held      = p.raw_buttons & btn_mask;
          diff        = prev_btn[i] ^ w.held;
          w.pressed   = diff & w.held;
          w.released  = diff & prev_btn[i];
          if (sx < -thr) w.dir = gic_pkg::DIR_LEFT;
          else if (sx > thr) w.dir = gic_pkg::DIR_RIGHT;
          if (sy < -thr) w.dir |= gic_pkg::DIR_DOWN;
          else if (sy > thr) w.dir |= gic_pkg::DIR_UP;
          ddiff          = prev_dir[i] ^ w.dir;
          w.dir_pressed  = ddiff & w.dir;
          w.dir_released = ddiff & prev_dir[i];
          if ((w.held != 0 || w.dir != 0) && w.held == prev_btn[i] && w.dir == prev_dir[i]) begin
            if (hold_cnt[i] != 16'hFFFF) begin
              per = (rep_period == 0) ? 1 : int'(rep_period);
              c = int'(hold_cnt[i]) + 1;
              hold_cnt[i] = c[15:0];
              if (c >= int'(rep_delay) && ((c - int'(rep_delay)) % per) == 0) w.pulse = 1'b1;
            end
          end else begin
            hold_cnt[i] = '0;
          end
          prev_btn[i] = w.held;
          prev_dir[i] = w.dir;
          if (live_cnt < gic_pkg::SUM_CAP) begin
            sum_x += sx;
            sum_y += sy;
            live_cnt++;
          end
        end
      end
      if (p.frame_last) begin
        if (live_cnt != 0) begin
          q      = sum_x / live_cnt;
          mean_x = q[7:0];
          q      = sum_y / live_cnt;
          mean_y = q[7:0];
          w.done = 1'b1;
        end
        sum_x    = 0;
        sum_y    = 0;
        live_cnt = 0;
      end
      w.avg_x = mean_x;
      w.avg_y = mean_y;
      due_words.push_back(w);
    endfunction

    function void show(string tag, pad_word_t w);
      $display("  %s held=%h pr=%h rl=%h dir=%h dpr=%h drl=%h pulse=%b lost=%b live=%b",
               tag, w.held, w.pressed, w.released, w.dir, w.dir_pressed, w.dir_released,
               w.pulse, w.lost, w.live);
      $display("  %s done=%b avg_x=%0d avg_y=%0d", tag, w.done,
               $signed(w.avg_x), $signed(w.avg_y));
    endfunction

    function void check_word(pad_word_t got);
      pad_word_t want;
      if (due_words.size() == 0) begin
        bad_words++;
        if (bad_words <= MAX_REPORTS) begin
          $display("Unexpected result word at %0t", $time);
          show("got", got);
        end
        return;
      end
      want = due_words.pop_front();
      if (got.held !== want.held || got.pressed !== want.pressed ||
          got.released !== want.released || got.dir !== want.dir ||
          got.dir_pressed !== want.dir_pressed || got.dir_released !== want.dir_released ||
          got.pulse !== want.pulse || got.lost !== want.lost || got.live !== want.live ||
          got.done !== want.done || got.avg_x !== want.avg_x || got.avg_y !== want.avg_y) begin
        bad_words++;
        if (bad_words <= MAX_REPORTS) begin
          $display("Result word mismatch at %0t", $time);
          show("expected", want);
          show("actual  ", got);
        end
      end
    endfunction

    function int outstanding();
      return due_words.size();
    endfunction

    function int failures();
      return bad_words + due_words.size();
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  port = '0;
  logic        port_error = 1'b0;
  logic [15:0] raw_buttons = '0;
  logic [7:0]  stick_x = '0;
  logic [7:0]  stick_y = '0;
  logic        frame_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] buttons_held;
  logic [15:0] buttons_pressed;
  logic [15:0] buttons_released;
  logic [3:0]  stick_dir;
  logic [3:0]  stick_dir_pressed;
  logic [3:0]  stick_dir_released;
  logic        repeat_pulse;
  logic        port_lost;
  logic        port_live;
  logic        frame_done;
  logic [7:0]  avg_stick_x;
  logic [7:0]  avg_stick_y;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [gic_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pad_tracker  tracker;
  int          send_pct = 0;
  int          recv_pct = 0;
  int          cur_thr = int'(gic_pkg::RESET_STICK_THRESHOLD);
  bit          hold_go = 1'b0;
  bit          hold_used = 1'b0;
  int          hold_left = 0;
  int          cycle_count = 0;
  logic [15:0] pat_btn [4] = '{default: '0};
  logic [7:0]  pat_x [4] = '{default: '0};
  logic [7:0]  pat_y [4] = '{default: '0};

  gamepad_input_conditioner_core u_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .port               (port),
    .port_error         (port_error),
    .raw_buttons        (raw_buttons),
    .stick_x            (stick_x),
    .stick_y            (stick_y),
    .frame_last         (frame_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .buttons_held       (buttons_held),
    .buttons_pressed    (buttons_pressed),
    .buttons_released   (buttons_released),
    .stick_dir          (stick_dir),
    .stick_dir_pressed  (stick_dir_pressed),
    .stick_dir_released (stick_dir_released),
    .repeat_pulse       (repeat_pulse),
    .port_lost          (port_lost),
    .port_live          (port_live),
    .frame_done         (frame_done),
    .avg_stick_x        (avg_stick_x),
    .avg_stick_y        (avg_stick_y),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // The long hold-off lets the block fill up while the sender keeps offering words.
  always @(posedge clk) begin
    if (hold_go && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_OFF_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      tracker.note_poll(poll_t'({port, port_error, raw_buttons, stick_x, stick_y, frame_last}));
    if (!rst && out_valid === 1'b1 && !out_stall)
      tracker.check_word(pad_word_t'({buttons_held, buttons_pressed, buttons_released,
                                      stick_dir, stick_dir_pressed, stick_dir_released,
                                      repeat_pulse, port_lost, port_live, frame_done,
                                      avg_stick_x, avg_stick_y}));
  end

  function automatic poll_t mk_poll(int prt, bit err, int btn, int sx, int sy, bit last);
    poll_t p;
    p.port        = prt[1:0];
    p.port_error  = err;
    p.raw_buttons = btn[15:0];
    p.stick_x     = sx[7:0];
    p.stick_y     = sy[7:0];
    p.frame_last  = last;
    return p;
  endfunction

  function automatic logic [7:0] pick_stick();
    int v;
    case ($urandom_range(0, 6))
      0: v = cur_thr;
      1: v = -cur_thr;
      2: v = cur_thr + 1;
      3: v = -cur_thr - 1;
      4: v = $urandom_range(0, 1) ? 127 : -128;
      5: v = 0;
      default: v = int'($urandom_range(0, 255));
    endcase
    return v[7:0];
  endfunction

  function automatic logic [15:0] pick_buttons();
    logic [15:0] b;
    case ($urandom_range(0, 4))
      0: b = 16'($urandom);
      1: b = 16'h0001 << $urandom_range(0, 15);
      2: b = '0;
      3: b = 16'hFFFF;
      default: b = 16'($urandom & $urandom);
    endcase
    return b;
  endfunction

  // Mostly repeats a port's current pattern so that hold counters climb.
  function automatic poll_t next_poll(bit allow_err);
    poll_t p;
    int    r;
    p.port = 2'($urandom_range(0, 3));
    r = $urandom_range(0, 99);
    if (r >= 75 && r < 92) begin
      pat_btn[p.port] = pick_buttons();
      pat_x[p.port]   = pick_stick();
      pat_y[p.port]   = pick_stick();
    end
    if (r < 92) begin
      p.raw_buttons = pat_btn[p.port];
      p.stick_x     = pat_x[p.port];
      p.stick_y     = pat_y[p.port];
    end else begin
      p.raw_buttons = 16'($urandom);
      p.stick_x     = 8'($urandom);
      p.stick_y     = 8'($urandom);
    end
    p.frame_last = ($urandom_range(0, 3) == 0);
    p.port_error = allow_err && ($urandom_range(0, 99) < 2);
    return p;
  endfunction

  task automatic send_poll(input poll_t p);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    port        <= p.port;
    port_error  <= p.port_error;
    raw_buttons <= p.raw_buttons;
    stick_x     <= p.stick_x;
    stick_y     <= p.stick_y;
    frame_last  <= p.frame_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_reg(idx, value);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] delay, input logic [15:0] period,
                           input logic [6:0] thr, input logic [15:0] mask,
                           input idle_mode_t mode);
    write_reg(gic_pkg::REG_REPEAT_DELAY, 32'(delay));
    write_reg(gic_pkg::REG_REPEAT_PERIOD, 32'(period));
    write_reg(gic_pkg::REG_STICK_THRESHOLD, 32'(thr));
    write_reg(gic_pkg::REG_BUTTON_MASK, 32'(mask));
    cur_thr  = int'(thr);
    send_pct = (mode == IDLE_SEND) ? 68 : (mode == IDLE_BOTH) ? 35 : 0;
    recv_pct <= (mode == IDLE_RECV) ? 68 : (mode == IDLE_BOTH) ? 35 : 0;
  endtask

  task automatic run_phase(input logic [15:0] delay, input logic [15:0] period,
                           input logic [6:0] thr, input logic [15:0] mask,
                           input idle_mode_t mode, input bit errors, input bit squeeze);
    configure(delay, period, thr, mask, mode);
    if (squeeze) hold_go <= 1'b1;
    for (int n = 0; n < ITEMS_PER_PHASE; n++) send_poll(next_poll(errors));
    settle();
  endtask

  // Reset register values; frames cover threshold edges, the sum cap and negative means.
  task automatic run_directed();
    send_poll(mk_poll(0, 0, 'hFFFF, 127, -128, 0));
    send_poll(mk_poll(1, 0, 'h0000, -128, 127, 0));
    send_poll(mk_poll(2, 0, 'h0001, 50, -50, 0));
    send_poll(mk_poll(3, 0, 'h8000, 51, -51, 1));
    send_poll(mk_poll(0, 0, 'h0000, 0, 0, 0));
    send_poll(mk_poll(1, 0, 'h0000, -128, 127, 0));
    send_poll(mk_poll(0, 0, 'h0000, -3, -2, 0));
    send_poll(mk_poll(2, 0, 'h0000, -2, -1, 1));
    send_poll(mk_poll(0, 0, 'h00F0, 10, 10, 0));
    send_poll(mk_poll(1, 0, 'h0F00, 20, -20, 0));
    send_poll(mk_poll(2, 0, 'hAAAA, 30, 30, 0));
    send_poll(mk_poll(3, 0, 'h5555, 40, -40, 0));
    send_poll(mk_poll(0, 0, 'h00F0, 100, 100, 0));
    send_poll(mk_poll(1, 0, 'h0F00, -100, -100, 1));
    send_poll(mk_poll(2, 0, 'h0000, -7, -128, 0));
    send_poll(mk_poll(3, 0, 'h0000, 0, 1, 1));
    settle();
  endtask

  initial begin
    tracker = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_phase(16'd2, 16'd0, 7'd50, 16'hFFFF, IDLE_NONE, 1'b0, 1'b0);
    run_phase(16'd0, 16'd1, 7'd0, 16'($urandom), IDLE_SEND, 1'b0, 1'b0);
    run_phase(16'd3, 16'd3, 7'd127, 16'h00FF, IDLE_RECV, 1'b0, 1'b1);
    run_phase(16'd65535, 16'd65535, 7'd20, 16'h0000, IDLE_BOTH, 1'b0, 1'b0);
    run_phase(16'd1, 16'd2, 7'd64, 16'($urandom), IDLE_SEND, 1'b0, 1'b0);
    run_phase(16'd4, 16'd2, 7'd90, 16'hFFFF, IDLE_BOTH, 1'b1, 1'b0);
    if (tracker.failures() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/gic_pkg.sv
sv/gic_div.sv
sv/gamepad_input_conditioner_core.sv
sim/tb_top.sv
